// ----- hdl/pch_pkg.sv -----
// Package for the pixel channel histogram: sizes, counter limits and item op codes.
// Used by pixel_channel_histogram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pch_pkg;

    // Histogram geometry.
    localparam int CHANNELS    = 3;
    localparam int BIN_COUNT   = 256;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_W       = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int CH_W        = 2;
    localparam int BYTE_W      = 8;
    localparam int OUT_W       = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_STRIDE  = 4;

    // A byte at or above this limit has no bin.
    localparam logic [BYTE_W:0] BIN_LIMIT = (BYTE_W + 1)'(BIN_COUNT);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Byte address of color_mode in the configuration space.
    localparam logic [PADDR_W-1:0] ADDR_COLOR_MODE = PADDR_W'(0 * REG_STRIDE);

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Stage-one bookkeeping for one item in flight.
    typedef struct packed {
        logic                valid;
        logic                is_read;
        logic                read_ok;
        logic [CH_W-1:0]     read_ch;
    } s1_ctrl_t;

endpackage : pch_pkg

`default_nettype wire

// ----- hdl/pixel_channel_histogram.sv -----
// Top level of the pixel channel histogram: three banks of saturating bin counters.
// Depends on pch_pkg and pch_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries op, pixel_word, read_channel and
//   read_bin. A count item bumps one bin (gray mode) or three bins (color mode);
//   a read item returns one bin through the output channel (out_valid / out_stall,
//   bin_count); a clear item zeroes every bin. Only read items give a result.
//   Each channel owns one RAM bank; an item reads its bins in the accept cycle,
//   and the next cycle adds one and writes back. The write of the previous item
//   is forwarded, so count items to the same bin may follow each other.
//   Throughput: one item per cycle while in_stall is low. A read result passes
//   through the stage-one register and then the output register to out_valid.
//   Clearing: after reset and after each clear item, a sweep writes zero into one
//   bin of every bank per cycle, through all BIN_COUNT (256) bins, with in_stall held high.
//   The APB port stays open during a sweep.
//   Stall: the output register holds a waiting result; the block keeps taking
//   items until a second read item reaches the write-back stage, and then raises
//   in_stall until the result is taken.
//   color_mode is written at byte address 0 and does not clear any bin.
`timescale 1ns / 1ps
`default_nettype none

module pixel_channel_histogram
    import pch_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Input item channel.
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         op,
    input  wire logic [31:0]        pixel_word,
    input  wire logic [CH_W-1:0]    read_channel,
    input  wire logic [BYTE_W-1:0]  read_bin,
    // Result item channel.
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [OUT_W-1:0]   bin_count,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    // Configuration register.
    logic color_mode_reg;

    // Clearing sweep.
    logic             clearing_reg, clearing_next;
    logic [BIN_W-1:0] clr_cnt_reg, clr_cnt_next;

    // Stage one (write-back) registers.
    s1_ctrl_t         s1_reg, s1_next;
    logic [CHANNELS-1:0] s1_hit_reg, s1_hit_next;
    logic [BIN_W-1:0] s1_addr_reg [CHANNELS];
    logic [BIN_W-1:0] s1_addr_next [CHANNELS];

    // Forwarding of the write made in the cycle the stage-one item read its bins.
    logic [CHANNELS-1:0] fwd_en_reg;
    logic [BIN_W-1:0]       fwd_addr_reg [CHANNELS];
    logic [COUNT_WIDTH-1:0] fwd_data_reg [CHANNELS];

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] bin_count_reg, bin_count_next;

    // RAM ports.
    logic [CHANNELS-1:0]    ram_we;
    logic [BIN_W-1:0]       ram_waddr [CHANNELS];
    logic [COUNT_WIDTH-1:0] ram_wdata [CHANNELS];
    logic [BIN_W-1:0]       ram_raddr [CHANNELS];
    logic [COUNT_WIDTH-1:0] ram_rdata [CHANNELS];
    logic [COUNT_WIDTH-1:0] cur_count [CHANNELS];
    logic [COUNT_WIDTH-1:0] inc_count [CHANNELS];

    logic blocked;
    logic advance;
    logic in_fire;
    logic out_free;
    logic cfg_write;
    op_t  in_op;
    logic [BYTE_W-1:0] byte_sel [CHANNELS];
    logic [COUNT_WIDTH-1:0] read_count;
    logic [OUT_W-1:0] read_value;

    // Handshake control.
    assign in_op    = op_t'(op);
    assign out_free = !out_valid_reg || !out_stall;
    assign blocked  = s1_reg.valid && s1_reg.is_read && !out_free;
    assign advance  = !blocked;
    assign in_stall = clearing_reg || blocked;
    assign in_fire  = in_valid && !in_stall;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_COLOR_MODE) ? {31'd0, color_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
        end
        else if (cfg_write && paddr == ADDR_COLOR_MODE)
        begin
            color_mode_reg <= pwdata[0];
        end
    end

    // Channel bytes of the incoming pixel.
    always_comb
    begin
        if (color_mode_reg)
        begin
            byte_sel[0] = pixel_word[23:16];
            byte_sel[1] = pixel_word[15:8];
            byte_sel[2] = pixel_word[7:0];
        end
        else
        begin
            byte_sel[0] = pixel_word[7:0];
            byte_sel[1] = pixel_word[15:8];
            byte_sel[2] = pixel_word[7:0];
        end
    end

    // Stage zero: bin addresses and the next stage-one contents.
    always_comb
    begin
        s1_next         = '0;
        s1_hit_next     = '0;
        s1_next.valid   = in_fire && (in_op inside {OP_COUNT, OP_READ});
        s1_next.is_read = (in_op == OP_READ);
        s1_next.read_ch = read_channel;
        s1_next.read_ok = (read_channel < CH_W'(CHANNELS))
                          && ({1'b0, read_bin} < BIN_LIMIT);
        for (int b = 0; b < CHANNELS; b++)
        begin
            if (in_op == OP_READ)
            begin
                ram_raddr[b] = read_bin[BIN_W-1:0];
            end
            else
            begin
                ram_raddr[b] = byte_sel[b][BIN_W-1:0];
            end
            s1_addr_next[b] = ram_raddr[b];
            s1_hit_next[b]  = (in_op == OP_COUNT) && ({1'b0, byte_sel[b]} < BIN_LIMIT)
                              && (color_mode_reg || b == 0);
        end
    end

    // Bin banks, one per channel.
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_bank
        pch_ram #(
            .WIDTH (COUNT_WIDTH),
            .DEPTH (BIN_COUNT)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (ram_waddr[g]),
            .wdata (ram_wdata[g]),
            .re    (advance),
            .raddr (ram_raddr[g]),
            .rdata (ram_rdata[g])
        );
    end

    // Stage one: forward, saturating increment and write back, or sweep zeros.
    always_comb
    begin
        for (int b = 0; b < CHANNELS; b++)
        begin
            if (fwd_en_reg[b] && fwd_addr_reg[b] == s1_addr_reg[b])
            begin
                cur_count[b] = fwd_data_reg[b];
            end
            else
            begin
                cur_count[b] = ram_rdata[b];
            end
            inc_count[b] = (cur_count[b] == COUNT_MAX) ? cur_count[b]
                                                       : cur_count[b] + 1'b1;
            if (clearing_reg)
            begin
                ram_we[b]    = 1'b1;
                ram_waddr[b] = clr_cnt_reg;
                ram_wdata[b] = '0;
            end
            else
            begin
                ram_we[b]    = s1_reg.valid && !s1_reg.is_read && s1_hit_reg[b];
                ram_waddr[b] = s1_addr_reg[b];
                ram_wdata[b] = inc_count[b];
            end
        end
    end

    // Read result, saturated to the output width; zero for an out-of-range channel or bin.
    always_comb
    begin
        case (s1_reg.read_ch)
            2'd0:    read_count = cur_count[0];
            2'd1:    read_count = cur_count[1];
            2'd2:    read_count = cur_count[2];
            default: read_count = '0;
        endcase
        if (!s1_reg.read_ok)
        begin
            read_value = '0;
        end
        else if (COUNT_WIDTH > OUT_W && (64'(read_count) >> OUT_W) != 64'd0)
        begin
            read_value = '1;
        end
        else
        begin
            read_value = OUT_W'(read_count);
        end
    end

    // Output register next state.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        bin_count_next = bin_count_reg;
        if (out_free)
        begin
            out_valid_next = s1_reg.valid && s1_reg.is_read;
            if (s1_reg.valid && s1_reg.is_read)
            begin
                bin_count_next = read_value;
            end
        end
    end

    // Clearing sweep next state.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_BIN)
            begin
                clearing_next = 1'b0;
                clr_cnt_next  = '0;
            end
        end
        else if (in_fire && in_op == OP_CLEAR)
        begin
            clearing_next = 1'b1;
            clr_cnt_next  = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_reg        <= '0;
            fwd_en_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                s1_reg     <= s1_next;
                fwd_en_reg <= ram_we;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        bin_count_reg <= bin_count_next;
        if (advance)
        begin
            s1_hit_reg <= s1_hit_next;
            for (int b = 0; b < CHANNELS; b++)
            begin
                s1_addr_reg[b]  <= s1_addr_next[b];
                fwd_addr_reg[b] <= ram_waddr[b];
                fwd_data_reg[b] <= ram_wdata[b];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_count = bin_count_reg;

    // The sweep owns the banks: no item enters while it runs.
    a_sweep_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> in_stall)
        else $error("item accepted during clearing sweep");

    // Bank 0 is written only by the sweep or by a count item in write-back.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we[0] |-> (clearing_reg || (s1_reg.valid && !s1_reg.is_read)))
        else $error("unexpected bank write");

    // A read item leaving write-back always lands in the output register.
    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.valid && s1_reg.is_read && advance) |=> out_valid_reg)
        else $error("read result lost");

    // A count write never lowers a bin of bank 0.
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we[0] && !clearing_reg) |-> (ram_wdata[0] >= cur_count[0]))
        else $error("bin count decreased");

    // A blocked read holds stage one and the forwarded write.
    a_block_holds: assert property (@(posedge clk) disable iff (!rst_n)
        blocked |=> ($stable(s1_reg) && $stable(fwd_en_reg)))
        else $error("stage one changed while blocked");

endmodule : pixel_channel_histogram

`default_nettype wire

// ----- hdl/pch_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read-first: a read and a write to the same address in one cycle return the old data.
`timescale 1ns / 1ps
`default_nettype none

module pch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : pch_ram

`default_nettype wire
